[rtl/ttws_pkg.sv]
package ttws_pkg;
    localparam int COORD_BITS = 16;
    localparam int CW = COORD_BITS;
    localparam int MW = 12;

    localparam logic [1:0] OP_RESET = 2'd0;
    localparam logic [1:0] OP_SHIFT = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] REG_ML = 2'd0;
    localparam logic [1:0] REG_MR = 2'd1;
    localparam logic [1:0] REG_MT = 2'd2;
    localparam logic [1:0] REG_MB = 2'd3;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [CW+1:0] t_wide;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture input word
        logic       win_upd;   // apply reset/shift to window (start wrap)
        logic       mod_start; // start offset reduction for box/quadrant
        logic       sel_dy;    // box 1 of shift
        logic [1:0] quad;
        logic       emit;      // load output register
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       mod_busy;
        logic       part_ok;   // current quadrant non-empty
        logic       op_ok;     // op produces output
        logic       is_shift;
    } t_sts;

    function automatic t_coord clampc(input t_wide v);
        t_wide hi;
        t_wide lo;
        hi = t_wide'({1'b0, {(CW-1){1'b1}}});
        lo = -hi - t_wide'(1);
        if (v > hi) return t_coord'(hi);
        if (v < lo) return t_coord'(lo);
        return t_coord'(v);
    endfunction
endpackage

[rtl/ttws_mod.sv]
module ttws_mod (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ttws_pkg::t_wide     i_val,
    input  ttws_pkg::t_wide     i_div,
    output logic                o_busy,
    output ttws_pkg::t_wide     o_rem
);
    import ttws_pkg::*;
    // restoring division of |v| by w, one bit a cycle, sign fixed at end
    localparam int W = CW + 2;
    localparam int CB = $clog2(W + 1);
    logic [W-1:0] r_q, n_q;
    logic [W:0]   r_r, n_r;
    logic [W-1:0] r_d;
    logic         r_neg, r_zero;
    logic [CB-1:0] r_cnt, n_cnt;
    logic         r_busy, n_busy;
    logic [W:0]   trial;
    t_wide        rem;

    always_comb begin
        n_q = r_q; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy;
        trial = {r_r[W-1:0], r_q[W-1]} - {1'b0, r_d};
        if (r_busy) begin
            n_q = {r_q[W-2:0], 1'b0};
            if (!trial[W]) begin
                n_r = trial;
            end else begin
                n_r = {r_r[W-1:0], r_q[W-1]};
            end
            n_cnt = r_cnt - CB'(1);
            if (r_cnt == CB'(1)) n_busy = 1'b0;
        end
        if (i_start) begin
            n_q = i_val[W-1] ? W'(-i_val) : W'(i_val);
            n_r = '0;
            n_cnt = CB'(W);
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) begin
            r_d    <= W'(i_div);
            r_neg  <= i_val[W-1];
            r_zero <= (i_div <= 0);
        end
    end

    always_comb begin
        rem = t_wide'(r_r[W-1:0]);
        if (r_zero) o_rem = '0;
        else if (r_neg && rem != 0) o_rem = t_wide'(r_d) - rem;
        else o_rem = rem;
    end
    assign o_busy = r_busy;
endmodule

[rtl/ttws_dp.sv]
module ttws_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ttws_pkg::t_cmd       i_cmd,
    output ttws_pkg::t_sts       o_sts,
    input  logic [1:0]           i_op,
    input  ttws_pkg::t_coord     i_rect_min_x,
    input  ttws_pkg::t_coord     i_rect_min_y,
    input  ttws_pkg::t_coord     i_rect_max_x,
    input  ttws_pkg::t_coord     i_rect_max_y,
    input  ttws_pkg::t_coord     i_move_x,
    input  ttws_pkg::t_coord     i_move_y,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [ttws_pkg::MW-1:0] i_cfg_data,
    output ttws_pkg::t_coord     o_part_min_x,
    output ttws_pkg::t_coord     o_part_min_y,
    output ttws_pkg::t_coord     o_part_max_x,
    output ttws_pkg::t_coord     o_part_max_y,
    output logic [15:0]          o_buf_offset_x,
    output logic [15:0]          o_buf_offset_y,
    output logic [1:0]           o_quadrant,
    output logic                 o_is_dirty,
    output logic                 o_last
);
    import ttws_pkg::*;
    logic [MW-1:0] r_ml, r_mr, r_mt, r_mb;
    t_coord r_wx0, r_wy0, r_wx1, r_wy1, r_sx, r_sy;
    logic   r_valid;
    logic [1:0] r_op;
    t_coord r_rx0, r_ry0, r_rx1, r_ry1, r_mx, r_my;
    t_wide  w, h;
    t_coord nwx0, nwx1, nwy0, nwy1;
    t_coord bx0, by0, bx1, by1;
    t_coord dxx0, dxx1, dyy0, dyy1, dyx0, dyx1;
    t_coord px0, py0, px1, py1;
    logic   r_wrap;   // split wrap pending after shift
    logic   mbx, mby;
    t_wide  remx, remy;
    logic   r_wrap2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ml <= '0; r_mr <= '0; r_mt <= '0; r_mb <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ML:  r_ml <= i_cfg_data;
                REG_MR:  r_mr <= i_cfg_data;
                REG_MT:  r_mt <= i_cfg_data;
                REG_MB:  r_mb <= i_cfg_data;
                default: r_ml <= r_ml;
            endcase
        end
    end

    assign w = t_wide'(r_wx1) - t_wide'(r_wx0);
    assign h = t_wide'(r_wy1) - t_wide'(r_wy0);

    always_comb begin
        nwx0 = clampc(t_wide'(r_wx0) - t_wide'(r_mx));
        nwx1 = clampc(t_wide'(r_wx1) - t_wide'(r_mx));
        nwy0 = clampc(t_wide'(r_wy0) - t_wide'(r_my));
        nwy1 = clampc(t_wide'(r_wy1) - t_wide'(r_my));
        if (r_op == OP_RESET) begin
            nwx0 = clampc(t_wide'(r_rx0) - t_wide'({1'b0, r_ml}));
            nwy0 = clampc(t_wide'(r_ry0) - t_wide'({1'b0, r_mt}));
            nwx1 = clampc(t_wide'(r_rx1) + t_wide'({1'b0, r_mr}));
            nwy1 = clampc(t_wide'(r_ry1) + t_wide'({1'b0, r_mb}));
        end
    end

    always_comb begin
        dxx0 = r_mx[CW-1] ? clampc(t_wide'(r_wx1) + t_wide'(r_mx)) : r_wx0;
        dxx1 = r_mx[CW-1] ? r_wx1 : clampc(t_wide'(r_wx0) + t_wide'(r_mx));
        dyy0 = r_my[CW-1] ? clampc(t_wide'(r_wy1) + t_wide'(r_my)) : r_wy0;
        dyy1 = r_my[CW-1] ? r_wy1 : clampc(t_wide'(r_wy0) + t_wide'(r_my));
        dyx0 = r_mx[CW-1] ? r_wx0 : dxx1;
        dyx1 = r_mx[CW-1] ? dxx0 : r_wx1;
        if (r_op == OP_QUERY) begin
            bx0 = r_rx0; by0 = r_ry0; bx1 = r_rx1; by1 = r_ry1;
        end else if (r_op == OP_RESET) begin
            bx0 = r_wx0; by0 = r_wy0; bx1 = r_wx1; by1 = r_wy1;
        end else if (i_cmd.sel_dy) begin
            bx0 = dyx0; by0 = dyy0; bx1 = dyx1; by1 = dyy1;
        end else begin
            bx0 = dxx0; by0 = r_wy0; bx1 = dxx1; by1 = r_wy1;
        end
        px0 = i_cmd.quad[0] ? bx0 : ((r_sx > bx0) ? r_sx : bx0);
        px1 = i_cmd.quad[0] ? ((r_sx < bx1) ? r_sx : bx1) : bx1;
        py0 = i_cmd.quad[1] ? by0 : ((r_sy > by0) ? r_sy : by0);
        py1 = i_cmd.quad[1] ? ((r_sy < by1) ? r_sy : by1) : by1;
    end

    // x unit reduces split wrap, then part offsets; y likewise
    ttws_mod u_modx (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_wrap || i_cmd.mod_start),
        .i_val(r_wrap ? t_wide'(r_sx) - t_wide'(r_wx0) : t_wide'(px0) - t_wide'(r_sx)),
        .i_div(w), .o_busy(mbx), .o_rem(remx)
    );
    ttws_mod u_mody (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_wrap || i_cmd.mod_start),
        .i_val(r_wrap ? t_wide'(r_sy) - t_wide'(r_wy0) : t_wide'(py0) - t_wide'(r_sy)),
        .i_div(h), .o_busy(mby), .o_rem(remy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_wx0 <= '0; r_wy0 <= '0; r_wx1 <= '0; r_wy1 <= '0;
            r_sx <= '0; r_sy <= '0;
            r_wrap <= 1'b0; r_wrap2 <= 1'b0;
        end else begin
            r_wrap <= i_cmd.win_upd && (r_op == OP_SHIFT);
            // a query leaves the window alone
            if (i_cmd.win_upd && r_op != OP_QUERY) begin
                r_wx0 <= nwx0; r_wx1 <= nwx1; r_wy0 <= nwy0; r_wy1 <= nwy1;
            end
            if (i_cmd.win_upd && r_op == OP_RESET) begin
                r_sx <= nwx0; r_sy <= nwy0; r_valid <= 1'b1;
            end else if (r_wrap2 && !mbx && !mby) begin
                r_sx <= CW'(t_wide'(r_wx0) + remx);
                r_sy <= CW'(t_wide'(r_wy0) + remy);
            end
            if (r_wrap) r_wrap2 <= 1'b1;
            else if (r_wrap2 && !mbx && !mby) r_wrap2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op;
            r_rx0 <= i_rect_min_x; r_ry0 <= i_rect_min_y;
            r_rx1 <= i_rect_max_x; r_ry1 <= i_rect_max_y;
            r_mx <= i_move_x; r_my <= i_move_y;
        end
        if (i_cmd.emit) begin
            o_part_min_x <= px0; o_part_min_y <= py0;
            o_part_max_x <= px1; o_part_max_y <= py1;
            o_buf_offset_x <= 16'(remx);
            o_buf_offset_y <= 16'(remy);
            o_quadrant <= i_cmd.quad;
            o_is_dirty <= (r_op != OP_QUERY);
            o_last <= i_cmd.last;
        end
    end

    assign o_sts.mod_busy = mbx || mby || r_wrap || r_wrap2;
    assign o_sts.part_ok  = (px1 > px0) && (py1 > py0);
    assign o_sts.op_ok    = (r_op == OP_RESET) ||
                            ((r_op == OP_SHIFT || r_op == OP_QUERY) && r_valid);
    assign o_sts.is_shift = (r_op == OP_SHIFT);
endmodule

[rtl/ttws_ctrl.sv]
module ttws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    output ttws_pkg::t_cmd o_cmd,
    input  ttws_pkg::t_sts i_sts
);
    import ttws_pkg::*;
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DEC  = 7'b0000010,
        S_WAIT = 7'b0000100,
        S_SCAN = 7'b0001000,
        S_MOD  = 7'b0010000,
        S_LOOK = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;
    t_state r_st, n_st;
    logic [2:0] r_idx, n_idx;   // box bit + quadrant
    logic [2:0] r_pend, n_pend; // index of the final non-empty part
    logic r_have, n_have;       // a non-empty part has been seen
    logic r_ov, n_ov;
    logic lastbox;

    assign lastbox = !i_sts.is_shift || r_idx[2];

    always_comb begin
        n_st = r_st; n_idx = r_idx; n_pend = r_pend; n_have = r_have;
        n_ov = r_ov;
        o_cmd = '0;
        o_cmd.sel_dy = r_idx[2];
        o_cmd.quad = r_idx[1:0];
        if (r_ov && !i_stall) n_ov = 1'b0;
        case (r_st)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) n_st = S_DEC;
            end
            S_DEC: begin
                n_idx = '0; n_have = 1'b0;
                if (!i_sts.op_ok) begin
                    n_st = S_IDLE;
                end else begin
                    o_cmd.win_upd = 1'b1;
                    n_st = S_WAIT;
                end
            end
            S_WAIT: if (!i_sts.mod_busy) n_st = S_LOOK;
            S_LOOK: begin
                // look-ahead pass: find the part that carries the last flag
                if (i_sts.part_ok) begin
                    n_pend = r_idx; n_have = 1'b1;
                end
                if (r_idx[1:0] == 2'd3 && lastbox) begin
                    n_idx = '0;
                    n_st = (i_sts.part_ok || r_have) ? S_SCAN : S_IDLE;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_SCAN: begin
                if (i_sts.part_ok) begin
                    o_cmd.mod_start = 1'b1;
                    n_st = S_MOD;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
            S_MOD: if (!i_sts.mod_busy) n_st = S_OUT;
            S_OUT: begin
                // emit the current part once the output register is free
                if (!r_ov || !i_stall) begin
                    o_cmd.emit = 1'b1;
                    n_ov = 1'b1;
                    o_cmd.last = (r_idx == r_pend);
                    if (o_cmd.last) n_st = S_IDLE;
                    else begin
                        n_idx = r_idx + 3'd1; n_st = S_SCAN;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_idx <= '0; r_pend <= '0; r_have <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_idx <= n_idx; r_pend <= n_pend; r_have <= n_have;
            r_ov <= n_ov;
        end
    end
    assign o_stall = (r_st != S_IDLE);
    assign o_valid = r_ov;
endmodule

[rtl/toroidal_tile_window_split_core.sv]
// channel | handshake         | payload
// in      | i_valid / o_stall | i_op, i_rect_*, i_move_*
// out     | o_valid / i_stall | o_part_*, o_buf_offset_*, o_quadrant, o_is_dirty, o_last
// cfg     | i_cfg_we          | i_cfg_idx, i_cfg_data
// one word at a time: decode and window update, then on a shift the split wrap, then
//   a look-ahead pass over each candidate part (4, or 8 on a shift)
// each emitted part takes a scan step, the remainder pair and the output register;
//   an empty candidate takes only a scan step; the remainder units are bit-serial
// reset is synchronous, active low; margins clear to zero, no window set
// a stalled output word holds until taken; the input stalls from accept to the last word
module toroidal_tile_window_split_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic signed [15:0] i_rect_min_x,
    input  logic signed [15:0] i_rect_min_y,
    input  logic signed [15:0] i_rect_max_x,
    input  logic signed [15:0] i_rect_max_y,
    input  logic signed [15:0] i_move_x,
    input  logic signed [15:0] i_move_y,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_part_min_x,
    output logic signed [15:0] o_part_min_y,
    output logic signed [15:0] o_part_max_x,
    output logic signed [15:0] o_part_max_y,
    output logic [15:0] o_buf_offset_x,
    output logic [15:0] o_buf_offset_y,
    output logic [1:0]  o_quadrant,
    output logic        o_is_dirty,
    output logic        o_last
);
    import ttws_pkg::*;
    t_cmd cmd;
    t_sts sts;

    // sequencer: decode, window update, look-ahead, quadrant scan, emission
    ttws_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cmd(cmd), .i_sts(sts)
    );

    // window state, part geometry and remainder units
    ttws_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_op(i_op),
        .i_rect_min_x(i_rect_min_x), .i_rect_min_y(i_rect_min_y),
        .i_rect_max_x(i_rect_max_x), .i_rect_max_y(i_rect_max_y),
        .i_move_x(i_move_x), .i_move_y(i_move_y),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_part_min_x(o_part_min_x), .o_part_min_y(o_part_min_y),
        .o_part_max_x(o_part_max_x), .o_part_max_y(o_part_max_y),
        .o_buf_offset_x(o_buf_offset_x), .o_buf_offset_y(o_buf_offset_y),
        .o_quadrant(o_quadrant), .o_is_dirty(o_is_dirty), .o_last(o_last)
    );

    // emitted word stays valid and its part_min_x holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_part_min_x))
        else $error("output word changed under stall");
    // no new word accepted while work is in flight
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted during work");
endmodule

[tb/tb_top.sv]
module tb_top;
    import ttws_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 300;
    localparam logic [1:0] OP_NONE = 2'd3;  // unused op code, block ignores it

    // one input word
    typedef struct {
        logic [1:0] op;
        t_coord x0, y0, x1, y1;
        t_coord mx, my;
    } win_op_t;

    // one emitted part
    typedef struct {
        logic [15:0] mnx, mny, mxx, mxy, offx, offy;
        logic [1:0]  quad;
        logic        dirty;
        logic        last;
    } part_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_op;
    logic signed [15:0] i_rect_min_x, i_rect_min_y, i_rect_max_x, i_rect_max_y;
    logic signed [15:0] i_move_x, i_move_y;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [11:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic signed [15:0] o_part_min_x, o_part_min_y, o_part_max_x, o_part_max_y;
    logic [15:0] o_buf_offset_x, o_buf_offset_y;
    logic [1:0]  o_quadrant;
    logic        o_is_dirty;
    logic        o_last;

    toroidal_tile_window_split_core dut (.*);

    // stimulus and expectations
    win_op_t pending_ops[$];
    part_t   expected_parts[$];
    win_op_t cur_op;
    int      errors;
    int      cycles;
    int      send_gap;
    int      recv_gap;
    int      hold_left;
    logic    hold_go;
    logic    quiet;      // no idling on either side

    // window model state
    longint  m_left, m_right, m_top, m_bottom;
    longint  w_x0, w_y0, w_x1, w_y1, sp_x, sp_y;
    bit      w_valid;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint sat(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint wrap(longint v, longint w);
        longint r;
        if (w <= 0) return 0;
        r = v % w;
        return (r < 0) ? r + w : r;
    endfunction

    // cut a box at the split lines, queue the non-empty quadrants
    function automatic int push_quadrants(longint x0, longint y0, longint x1, longint y1,
                                          logic dirty);
        longint px0[4], py0[4], px1[4], py1[4];
        part_t  p;
        int     n;
        n = 0;
        px0[0] = (sp_x > x0) ? sp_x : x0; py0[0] = (sp_y > y0) ? sp_y : y0;
        px1[0] = x1;                      py1[0] = y1;
        px0[1] = x0;                      py0[1] = py0[0];
        px1[1] = (sp_x < x1) ? sp_x : x1; py1[1] = y1;
        px0[2] = px0[0];                  py0[2] = y0;
        px1[2] = x1;                      py1[2] = (sp_y < y1) ? sp_y : y1;
        px0[3] = x0;                      py0[3] = y0;
        px1[3] = px1[1];                  py1[3] = py1[2];
        for (int q = 0; q < 4; q++) begin
            if (px1[q] <= px0[q] || py1[q] <= py0[q]) continue;
            p.mnx   = 16'(px0[q]);
            p.mny   = 16'(py0[q]);
            p.mxx   = 16'(px1[q]);
            p.mxy   = 16'(py1[q]);
            p.offx  = 16'(wrap(px0[q] - sp_x, w_x1 - w_x0));
            p.offy  = 16'(wrap(py0[q] - sp_y, w_y1 - w_y0));
            p.quad  = 2'(q);
            p.dirty = dirty;
            p.last  = 1'b0;
            expected_parts.insert(expected_parts.size(), p);
            n++;
        end
        return n;
    endfunction

    // apply one accepted word to the window model, queue its parts
    task automatic apply_window_op(win_op_t w);
        longint mx, my, ax0, ax1, by0, by1, bx0, bx1;
        int     n;
        n = 0;
        mx = w.mx;
        my = w.my;
        if (w.op == OP_RESET) begin
            w_x0 = sat(longint'(w.x0) - m_left);
            w_y0 = sat(longint'(w.y0) - m_top);
            w_x1 = sat(longint'(w.x1) + m_right);
            w_y1 = sat(longint'(w.y1) + m_bottom);
            sp_x = w_x0;
            sp_y = w_y0;
            w_valid = 1'b1;
            n = push_quadrants(w_x0, w_y0, w_x1, w_y1, 1'b1);
        end else if (w.op == OP_SHIFT && w_valid) begin
            w_x0 = sat(w_x0 - mx);
            w_x1 = sat(w_x1 - mx);
            w_y0 = sat(w_y0 - my);
            w_y1 = sat(w_y1 - my);
            sp_x = w_x0 + wrap(sp_x - w_x0, w_x1 - w_x0);
            sp_y = w_y0 + wrap(sp_y - w_y0, w_y1 - w_y0);
            // strip uncovered by the horizontal move, then the vertical one
            ax0 = (mx < 0) ? sat(w_x1 + mx) : w_x0;
            ax1 = (mx < 0) ? w_x1 : sat(w_x0 + mx);
            by0 = (my < 0) ? sat(w_y1 + my) : w_y0;
            by1 = (my < 0) ? w_y1 : sat(w_y0 + my);
            bx0 = (mx < 0) ? w_x0 : ax1;
            bx1 = (mx < 0) ? ax0 : w_x1;
            n = push_quadrants(ax0, w_y0, ax1, w_y1, 1'b1);
            n += push_quadrants(bx0, by0, bx1, by1, 1'b1);
        end else if (w.op == OP_QUERY && w_valid) begin
            n = push_quadrants(w.x0, w.y0, w.x1, w.y1, 1'b0);
        end
        if (n > 0) expected_parts[$].last = 1'b1;
    endtask

    task automatic report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // sender: one word offered at a time, random bursts of idle
    always @(posedge i_clk) begin
        logic nv;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            nv = i_valid;
            if (i_valid && !o_stall) begin
                apply_window_op(cur_op);
                nv = 1'b0;
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0) begin
                    if (!quiet && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 10);
                    end else begin
                        cur_op = pending_ops[0];
                        pending_ops.delete(0);
                        nv = 1'b1;
                    end
                end
            end
            i_valid      <= nv;
            i_op         <= cur_op.op;
            i_rect_min_x <= cur_op.x0;
            i_rect_min_y <= cur_op.y0;
            i_rect_max_x <= cur_op.x1;
            i_rect_max_y <= cur_op.y1;
            i_move_x     <= cur_op.mx;
            i_move_y     <= cur_op.my;
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge i_clk) begin
        if (hold_go) hold_left <= HOLD_CYCLES;
        else if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // receiver: check each taken word against the oldest expectation
    always @(posedge i_clk) begin
        part_t e;
        logic  ns;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_parts.size() == 0) begin
                    report("unexpected word, part_min_x", o_part_min_x, 16'h0000);
                end else begin
                    e = expected_parts[0];
                    expected_parts.delete(0);
                    if (o_part_min_x !== e.mnx)   report("part_min_x", o_part_min_x, e.mnx);
                    if (o_part_min_y !== e.mny)   report("part_min_y", o_part_min_y, e.mny);
                    if (o_part_max_x !== e.mxx)   report("part_max_x", o_part_max_x, e.mxx);
                    if (o_part_max_y !== e.mxy)   report("part_max_y", o_part_max_y, e.mxy);
                    if (o_buf_offset_x !== e.offx) report("buf_offset_x", o_buf_offset_x, e.offx);
                    if (o_buf_offset_y !== e.offy) report("buf_offset_y", o_buf_offset_y, e.offy);
                    if (o_quadrant !== e.quad)    report("quadrant", 16'(o_quadrant), 16'(e.quad));
                    if (o_is_dirty !== e.dirty)   report("is_dirty", 16'(o_is_dirty), 16'(e.dirty));
                    if (o_last !== e.last)        report("last", 16'(o_last), 16'(e.last));
                end
            end
            if (hold_left > 0 || hold_go) begin
                ns = 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                ns = 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 10);
                ns = 1'b1;
            end else begin
                ns = 1'b0;
            end
            i_stall <= ns;
        end
    end

    task automatic add_op(logic [1:0] op, int x0, int y0, int x1, int y1, int mx, int my);
        win_op_t w;
        w.op = op;
        w.x0 = t_coord'(x0); w.y0 = t_coord'(y0);
        w.x1 = t_coord'(x1); w.y1 = t_coord'(y1);
        w.mx = t_coord'(mx); w.my = t_coord'(my);
        pending_ops.insert(pending_ops.size(), w);
    endtask

    // mostly close to a point, sometimes anywhere in the 16-bit range
    function automatic int near(longint c, int span);
        if ($urandom_range(0, 4) == 0) return int'(t_coord'($urandom));
        return int'(c) + $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic int small_move();
        if ($urandom_range(0, 6) == 0) return int'(t_coord'($urandom));
        return $urandom_range(0, 80) - 40;
    endfunction

    task automatic add_random_op();
        int k, x0, y0;
        k = $urandom_range(0, 99);
        if (k < 10) begin
            x0 = near(0, 300);
            y0 = near(0, 300);
            if ($urandom_range(0, 5) == 0)
                add_op(OP_RESET, x0, y0, int'(t_coord'($urandom)), int'(t_coord'($urandom)),
                       int'(t_coord'($urandom)), int'(t_coord'($urandom)));
            else
                add_op(OP_RESET, x0, y0, x0 + $urandom_range(0, 150), y0 + $urandom_range(0, 150),
                       int'(t_coord'($urandom)), int'(t_coord'($urandom)));
        end else if (k < 13) begin
            add_op(OP_NONE, int'(t_coord'($urandom)), int'(t_coord'($urandom)),
                   int'(t_coord'($urandom)), int'(t_coord'($urandom)),
                   int'(t_coord'($urandom)), int'(t_coord'($urandom)));
        end else if (k < 50) begin
            add_op(OP_SHIFT, int'(t_coord'($urandom)), int'(t_coord'($urandom)),
                   int'(t_coord'($urandom)), int'(t_coord'($urandom)),
                   small_move(), small_move());
        end else begin
            add_op(OP_QUERY, near(w_x0, 60), near(w_y0, 60), near(w_x1, 60), near(w_y1, 60),
                   int'(t_coord'($urandom)), int'(t_coord'($urandom)));
        end
    endtask

    // one register write on the next edge
    task automatic write_reg(logic [1:0] idx, int v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= 12'(v);
    endtask

    // margins are only written while the block is idle
    task automatic set_margins(int l, int r, int t, int b);
        write_reg(REG_ML, l);
        write_reg(REG_MR, r);
        write_reg(REG_MT, t);
        write_reg(REG_MB, b);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_left = l; m_right = r; m_top = t; m_bottom = b;
    endtask

    // wait until everything is sent and every part has come back
    task automatic drain();
        while (pending_ops.size() > 0 || i_valid || expected_parts.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) add_random_op();
    endtask

    initial begin
        errors = 0; cycles = 0; send_gap = 0; recv_gap = 0;
        hold_left = 0; hold_go = 1'b0; quiet = 1'b0;
        m_left = 0; m_right = 0; m_top = 0; m_bottom = 0;
        w_x0 = 0; w_y0 = 0; w_x1 = 0; w_y1 = 0; sp_x = 0; sp_y = 0; w_valid = 1'b0;
        cur_op = '{OP_NONE, 0, 0, 0, 0, 0, 0};
        i_rst_n = 1'b0; i_valid = 1'b0; i_stall = 1'b0;
        i_op = 2'd0; i_rect_min_x = 0; i_rect_min_y = 0; i_rect_max_x = 0; i_rect_max_y = 0;
        i_move_x = 0; i_move_y = 0;
        i_cfg_we = 1'b0; i_cfg_idx = 2'd0; i_cfg_data = 12'd0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no window yet: shift and query are dropped, so is the unused op
        add_op(OP_QUERY, -10, -10, 10, 10, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, 5, 5);
        add_op(OP_NONE, -1, -1, -1, -1, -1, -1);
        drain();

        // directed: split cases, moves both ways, saturation, empty windows
        set_margins(2, 3, 1, 4);
        add_op(OP_RESET, 0, 0, 16, 8, 0, 0);
        add_op(OP_QUERY, -5, -5, 30, 20, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, 3, 2);
        add_op(OP_QUERY, -100, -100, 100, 100, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, -5, -7);
        add_op(OP_QUERY, 0, 0, 1, 1, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, 40, -50);
        add_op(OP_SHIFT, 0, 0, 0, 0, 0, 0);
        add_op(OP_NONE, 5, 5, 6, 6, 1, 1);
        add_op(OP_SHIFT, 0, 0, 0, 0, -32768, 32767);
        add_op(OP_QUERY, -32768, -32768, 32767, 32767, 0, 0);
        add_op(OP_RESET, -32768, -32768, 32767, 32767, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, 1, -1);
        add_op(OP_QUERY, 32767, 32767, -32768, -32768, 0, 0);
        add_op(OP_RESET, 10, 10, 3, 3, 0, 0);
        add_op(OP_QUERY, 0, 0, 20, 20, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, 3, 3);
        add_op(OP_RESET, 100, 100, 101, 101, 0, 0);
        add_op(OP_SHIFT, 0, 0, 0, 0, 2, 1);
        add_op(OP_QUERY, 90, 90, 110, 110, 0, 0);
        drain();

        // widest margins; receiver holds off so the block backs up
        set_margins(4095, 4095, 4095, 4095);
        hold_go <= 1'b1;
        @(posedge i_clk);
        hold_go <= 1'b0;
        add_op(OP_RESET, 0, 0, 20, 20, 0, 0);
        random_phase(100);
        drain();

        set_margins(0, 0, 0, 0);
        add_op(OP_RESET, -20, -20, 40, 30, 0, 0);
        random_phase(100);
        drain();

        set_margins($urandom_range(0, 4095), $urandom_range(0, 40),
                    $urandom_range(0, 4095), $urandom_range(0, 40));
        random_phase(100);
        drain();

        // final stretch without idling
        set_margins(0, 4095, $urandom_range(0, 15), 4095);
        quiet = 1'b1;
        random_phase(90);
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/ttws_pkg.sv
rtl/ttws_mod.sv
rtl/ttws_dp.sv
rtl/ttws_ctrl.sv
rtl/toroidal_tile_window_split_core.sv
tb/tb_top.sv
